// File: src/sorted_range_table_coverage_defines.svh
// Assertion macros for the sorted range table.
// Included by modules that carry concurrent assertions; no other dependency.
`ifndef SORTED_RANGE_TABLE_COVERAGE_DEFINES_SVH
`define SORTED_RANGE_TABLE_COVERAGE_DEFINES_SVH
`ifndef SYNTHESIS
// Check that an antecedent implies a consequent in the next cycle.
`define SRTC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
// Check that an antecedent implies a consequent in the same cycle.
`define SRTC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`else
`define SRTC_ASSERT_NEXT(label, clk, rst, ante, cons)
`define SRTC_ASSERT_SAME(label, clk, rst, ante, cons)
`endif
`endif

// File: src/srtc_pkg.sv
// Shared types and constants of the sorted range table.
// No dependencies.
package srtc_pkg;
   localparam int unsigned MAX_RANGES_DEF = 64;
   localparam int unsigned ADDR_W = 64;

   typedef enum logic [1:0] {
      REQ_ADD    = 2'd0,
      REQ_REMOVE = 2'd1,
      REQ_QUERY  = 2'd2,
      REQ_NONE   = 2'd3
   } req_type_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_OVERFLOW = 2'd1,
      ST_FULL     = 2'd2
   } status_type;

   // Memory port command from sequencer to the entry store.
   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } mem_ctl_type;
endpackage

// File: src/srtc_store.sv
// Entry store: start/end memory pair, one write and one read port.
// Depends on srtc_pkg.
module srtc_store #(
   parameter int unsigned AW = 6
) (
   input  logic                       clock,
   input  srtc_pkg::mem_ctl_type      ctl,
   input  logic [AW-1:0]              rd_addr,
   input  logic [AW-1:0]              wr_addr,
   input  logic [srtc_pkg::ADDR_W-1:0] wr_start,
   input  logic [srtc_pkg::ADDR_W-1:0] wr_end,
   output logic [srtc_pkg::ADDR_W-1:0] rd_start,
   output logic [srtc_pkg::ADDR_W-1:0] rd_end
);
   import srtc_pkg::*;

   logic [ADDR_W-1:0] start_mem [2**AW];
   logic [ADDR_W-1:0] end_mem   [2**AW];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         start_mem[wr_addr] <= wr_start;
         end_mem[wr_addr]   <= wr_end;
      end
      if (ctl.rd_en) begin
         rd_start <= start_mem[rd_addr];
         rd_end   <= end_mem[rd_addr];
      end
   end
endmodule

// File: src/srtc_seq.sv
// Request sequencer: walks, shifts and scans the entry store one entry at a time.
// Depends on srtc_pkg and the assertion macro header.
`include "sorted_range_table_coverage_defines.svh"
module srtc_seq #(
   parameter int unsigned MAX_RANGES = 64,
   parameter int unsigned AW = 6,
   parameter int unsigned CW = 7
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [1:0]                  req_type,
   input  logic [srtc_pkg::ADDR_W-1:0] req_range_start,
   input  logic [srtc_pkg::ADDR_W-1:0] req_range_bound,
   output logic                        rsp_valid,
   output logic [1:0]                  rsp_status,
   output logic                        rsp_covered,
   output logic [6:0]                  rsp_entry_count,
   output srtc_pkg::mem_ctl_type       mem_ctl,
   output logic [AW-1:0]               mem_rd_addr,
   output logic [AW-1:0]               mem_wr_addr,
   output logic [srtc_pkg::ADDR_W-1:0] mem_wr_start,
   output logic [srtc_pkg::ADDR_W-1:0] mem_wr_end,
   input  logic [srtc_pkg::ADDR_W-1:0] mem_rd_start,
   input  logic [srtc_pkg::ADDR_W-1:0] mem_rd_end
);
   import srtc_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_A_FIND, S_A_SHIFT, S_A_PUT,
      S_R_FIND, S_R_SHIFT, S_Q_FIND, S_Q_BACK, S_Q_FWD, S_DONE
   } state_type;

   state_type         state_ff;
   logic [ADDR_W-1:0] s_ff, b_ff, reached_ff;
   logic [CW-1:0]     count_ff;   // stored entries
   logic [CW-1:0]     idx_ff;     // address being read, valid next cycle
   logic              pend_ff;    // a read is in flight
   logic [CW-1:0]     pos_ff;     // split / insertion position
   logic              hit_ff;
   logic              cov_ff;
   logic [1:0]        status_ff;
   logic              rvalid_ff;
   logic              wr_en_ff;
   logic              rd_en_in;
   logic [ADDR_W:0]   sum_in;
   logic [ADDR_W:0]   reach1_in;

   assign sum_in    = {1'b0, req_range_start} + {1'b0, req_range_bound};
   assign reach1_in = {1'b0, reached_ff} + {{ADDR_W{1'b0}}, 1'b1};
   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rvalid_ff;
   assign rsp_status = status_ff;
   assign rsp_covered = cov_ff;
   assign rsp_entry_count = 7'(count_ff);
   assign mem_ctl.rd_en = rd_en_in;
   assign mem_ctl.wr_en = wr_en_ff;

   // Hold control state, registered outputs and memory write commands.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         rvalid_ff <= 1'b0;
         pend_ff   <= 1'b0;
         wr_en_ff  <= 1'b0;
      end else begin
         rvalid_ff <= 1'b0;
         wr_en_ff  <= 1'b0;
         pend_ff   <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  s_ff       <= req_range_start;
                  b_ff       <= req_range_bound;
                  reached_ff <= req_range_start;
                  status_ff  <= ST_OK;
                  cov_ff     <= 1'b0;
                  hit_ff     <= 1'b0;
                  idx_ff     <= '0;
                  pos_ff     <= '0;
                  priority case (req_type_type'(req_type))
                     REQ_ADD: begin
                        if (sum_in[ADDR_W]) begin
                           status_ff <= ST_OVERFLOW;
                           state_ff  <= S_DONE;
                        end else if (count_ff >= CW'(MAX_RANGES)) begin
                           status_ff <= ST_FULL;
                           state_ff  <= S_DONE;
                        end else begin
                           b_ff     <= sum_in[ADDR_W-1:0];
                           state_ff <= S_A_FIND;
                        end
                     end
                     REQ_REMOVE: state_ff <= S_R_FIND;
                     REQ_QUERY: begin
                        if (req_range_start > req_range_bound) state_ff <= S_DONE;
                        else state_ff <= S_Q_FIND;
                     end
                     default: state_ff <= S_DONE;
                  endcase
               end
            end
            // Find first entry with start > s.
            S_A_FIND, S_Q_FIND: begin
               if (pend_ff && mem_rd_start > s_ff) begin
                  pos_ff <= idx_ff - CW'(1);
                  idx_ff <= (state_ff == S_A_FIND) ? count_ff : idx_ff - CW'(1);
                  state_ff <= (state_ff == S_A_FIND) ? S_A_SHIFT : S_Q_BACK;
               end else if (idx_ff == count_ff) begin
                  pos_ff <= count_ff;
                  idx_ff <= count_ff;
                  state_ff <= (state_ff == S_A_FIND) ? S_A_SHIFT : S_Q_BACK;
               end else begin
                  pend_ff <= 1'b1;
                  idx_ff  <= idx_ff + CW'(1);
               end
            end
            // Move entries up by one from the top down to pos, then write the new entry at pos.
            S_A_SHIFT: begin
               if (pend_ff) begin
                  wr_en_ff     <= 1'b1;
                  mem_wr_addr  <= AW'(idx_ff + CW'(1));
                  mem_wr_start <= mem_rd_start;
                  mem_wr_end   <= mem_rd_end;
               end else if (idx_ff == pos_ff) begin
                  wr_en_ff     <= 1'b1;
                  mem_wr_addr  <= AW'(pos_ff);
                  mem_wr_start <= s_ff;
                  mem_wr_end   <= b_ff;
                  count_ff     <= count_ff + CW'(1);
                  state_ff     <= S_DONE;
               end else begin
                  pend_ff <= 1'b1;
                  idx_ff  <= idx_ff - CW'(1);
               end
            end
            S_A_PUT: state_ff <= S_DONE;
            // Find the first exact match.
            S_R_FIND: begin
               if (pend_ff && mem_rd_start == s_ff && mem_rd_end == b_ff) begin
                  state_ff <= S_R_SHIFT;
               end else if (idx_ff == count_ff) begin
                  state_ff <= S_DONE;
               end else begin
                  pend_ff <= 1'b1;
                  idx_ff  <= idx_ff + CW'(1);
               end
            end
            // Move entries down by one over the removed slot.
            S_R_SHIFT: begin
               if (pend_ff) begin
                  wr_en_ff     <= 1'b1;
                  mem_wr_addr  <= AW'(idx_ff - CW'(2));
                  mem_wr_start <= mem_rd_start;
                  mem_wr_end   <= mem_rd_end;
               end else if (idx_ff == count_ff) begin
                  count_ff <= count_ff - CW'(1);
                  state_ff <= S_DONE;
               end else begin
                  pend_ff <= 1'b1;
                  idx_ff  <= idx_ff + CW'(1);
               end
            end
            // Walk entries below the split, downward.
            S_Q_BACK: begin
               if (pend_ff && mem_rd_end > s_ff) begin
                  hit_ff <= 1'b1;
                  if (mem_rd_end > reached_ff) reached_ff <= mem_rd_end;
                  if (mem_rd_end >= b_ff || reached_ff >= b_ff) begin
                     cov_ff <= 1'b1;
                     state_ff <= S_DONE;
                  end
               end
               if (!(pend_ff && mem_rd_end > s_ff &&
                     (mem_rd_end >= b_ff || reached_ff >= b_ff))) begin
                  if (pend_ff) begin
                     // result consumed; idx_ff points at next read
                  end else if (idx_ff == '0) begin
                     if (!hit_ff) state_ff <= S_DONE;
                     else begin
                        idx_ff   <= pos_ff;
                        state_ff <= S_Q_FWD;
                     end
                  end else begin
                     pend_ff <= 1'b1;
                     idx_ff  <= idx_ff - CW'(1);
                  end
               end
            end
            // Walk entries at and above the split, upward.
            S_Q_FWD: begin
               if (pend_ff) begin
                  if (mem_rd_start > reached_ff &&
                      {1'b0, mem_rd_start} > reach1_in) begin
                     cov_ff <= (reached_ff >= b_ff);
                     state_ff <= S_DONE;
                  end else if (mem_rd_end > reached_ff) begin
                     reached_ff <= mem_rd_end;
                     if (mem_rd_end >= b_ff) begin
                        cov_ff <= 1'b1;
                        state_ff <= S_DONE;
                     end
                  end
               end else if (idx_ff == count_ff) begin
                  cov_ff <= (reached_ff >= b_ff);
                  state_ff <= S_DONE;
               end else begin
                  pend_ff <= 1'b1;
                  idx_ff  <= idx_ff + CW'(1);
               end
            end
            S_DONE: begin
               rvalid_ff <= 1'b1;
               state_ff  <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // Issue a read in the cycle that starts it, so data lands with pend_ff.
   always_comb begin
      unique case (state_ff)
         S_A_FIND, S_Q_FIND:
            rd_en_in = !(pend_ff && mem_rd_start > s_ff) && (idx_ff != count_ff);
         S_A_SHIFT:
            rd_en_in = !pend_ff && (idx_ff != pos_ff);
         S_R_FIND:
            rd_en_in = !(pend_ff && mem_rd_start == s_ff && mem_rd_end == b_ff) &&
                       (idx_ff != count_ff);
         S_R_SHIFT, S_Q_FWD:
            rd_en_in = !pend_ff && (idx_ff != count_ff);
         S_Q_BACK:
            rd_en_in = !pend_ff && (idx_ff != '0);
         default:
            rd_en_in = 1'b0;
      endcase
   end

   // Read address: idx for upward walks, idx minus one for downward walks.
   always_comb begin
      unique case (state_ff)
         S_A_SHIFT, S_Q_BACK: mem_rd_addr = AW'(idx_ff - CW'(1));
         default:             mem_rd_addr = AW'(idx_ff);
      endcase
   end

   `SRTC_ASSERT_NEXT(a_done_resp, clock, reset, state_ff == S_DONE, rsp_valid)
   `SRTC_ASSERT_SAME(a_count_max, clock, reset, 1'b1, count_ff <= CW'(MAX_RANGES))
   `SRTC_ASSERT_SAME(a_no_rw_idle, clock, reset, state_ff == S_IDLE, !pend_ff)
   `SRTC_ASSERT_NEXT(a_full_nochg, clock, reset,
      rsp_valid == 1'b0 && state_ff == S_DONE && status_ff != ST_OK,
      $stable(count_ff))
endmodule

// File: src/sorted_range_table_coverage.sv
// Sorted range table with coverage check.
// Command channel: pulse start while busy is low; req_type, req_range_start
// and req_range_bound are taken at that edge. Add inserts [start,start+len)
// after equal starts, remove deletes the first exact match, query reports
// whether the stored ranges cover start..end (a one-address gap still joins).
// Result: rsp_valid is high for one cycle with rsp_status, rsp_covered and
// rsp_entry_count; the receiver cannot stall and must take it then.
// Rejected adds, the unused type and queries with start > end go straight to
// the result; other words search the table and then move or walk entries, one
// read at a time, through the single read port of the entry memory.
// busy is high from the accepting edge until the result cycle begins; the
// next word can be accepted in the result cycle.
// Reset: synchronous, clears the entry count; memory contents need no clear.
// Depends on srtc_pkg, srtc_store and srtc_seq.
module sorted_range_table_coverage #(
   parameter int unsigned MAX_RANGES = srtc_pkg::MAX_RANGES_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [1:0]                  req_type,
   input  logic [srtc_pkg::ADDR_W-1:0] req_range_start,
   input  logic [srtc_pkg::ADDR_W-1:0] req_range_bound,
   output logic                        rsp_valid,
   output logic [1:0]                  rsp_status,
   output logic                        rsp_covered,
   output logic [6:0]                  rsp_entry_count
);
   import srtc_pkg::*;

   localparam int unsigned AW = $clog2(MAX_RANGES);
   localparam int unsigned CW = $clog2(MAX_RANGES + 1) + 1;

   mem_ctl_type       mem_ctl;
   logic [AW-1:0]     rd_addr, wr_addr;
   logic [ADDR_W-1:0] wr_start, wr_end, rd_start, rd_end;

   srtc_seq #(.MAX_RANGES(MAX_RANGES), .AW(AW), .CW(CW)) u_seq (
      .clock, .reset, .start, .busy, .req_type, .req_range_start, .req_range_bound,
      .rsp_valid, .rsp_status, .rsp_covered, .rsp_entry_count,
      .mem_ctl, .mem_rd_addr(rd_addr), .mem_wr_addr(wr_addr),
      .mem_wr_start(wr_start), .mem_wr_end(wr_end),
      .mem_rd_start(rd_start), .mem_rd_end(rd_end)
   );

   srtc_store #(.AW(AW)) u_store (
      .clock, .ctl(mem_ctl), .rd_addr, .wr_addr,
      .wr_start, .wr_end, .rd_start, .rd_end
   );
endmodule

// File: verif/tb_sorted_range_table_coverage.sv
// Self-checking testbench for the sorted range table with coverage check.
// Drives add/remove/query words through the start/busy port and checks each
// response against a behavioral table model. Depends on srtc_pkg and the dut.
`timescale 1ns / 100ps

module tb_sorted_range_table_coverage;
   import srtc_pkg::*;

   localparam int unsigned TBL_DEPTH = MAX_RANGES_DEF;
   localparam int unsigned RAND_WORDS = 1350;
   localparam int unsigned CYCLE_LIMIT = 2000000;
   localparam logic [63:0] ADDR_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

   typedef struct {
      logic [1:0]  st;
      logic        cov;
      logic [6:0]  cnt;
   } rsp_word_type;

   typedef struct {
      logic [1:0]   kind;
      logic [63:0]  lo;
      logic [63:0]  bnd;
      bit           has_fixed;
      rsp_word_type fixed;
   } dir_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_type = REQ_NONE;
   logic [63:0] req_range_start = '0;
   logic [63:0] req_range_bound = '0;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic        rsp_covered;
   logic [6:0]  rsp_entry_count;

   // model table
   logic [63:0] tbl_lo [TBL_DEPTH];
   logic [63:0] tbl_hi [TBL_DEPTH];
   int unsigned tbl_cnt;

   rsp_word_type pending_rsp [$];
   int unsigned err_cnt = 0;
   int unsigned cycle_cnt = 0;
   int unsigned n_add = 0, n_ovf = 0, n_full = 0, n_rem = 0, n_hit = 0, n_miss = 0;

   sorted_range_table_coverage dut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // timeout watchdog
   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt > CYCLE_LIMIT) begin
         $display("sorted_range_table_coverage regression: fail");
         $finish;
      end
   end

   function automatic logic table_add(logic [63:0] s, logic [63:0] len, output logic [1:0] st);
      int unsigned pos;
      st = ST_OK;
      if (len > ADDR_MAX - s) begin
         st = ST_OVERFLOW;
         return 1'b0;
      end
      if (tbl_cnt >= TBL_DEPTH) begin
         st = ST_FULL;
         return 1'b0;
      end
      pos = 0;
      while (pos < tbl_cnt && tbl_lo[pos] <= s) pos++;
      for (int unsigned i = tbl_cnt; i > pos; i--) begin
         tbl_lo[i] = tbl_lo[i-1];
         tbl_hi[i] = tbl_hi[i-1];
      end
      tbl_lo[pos] = s;
      tbl_hi[pos] = s + len;
      tbl_cnt++;
      return 1'b1;
   endfunction

   function automatic void table_remove(logic [63:0] s, logic [63:0] e);
      for (int unsigned i = 0; i < tbl_cnt; i++) begin
         if (tbl_lo[i] == s && tbl_hi[i] == e) begin
            for (int unsigned j = i; j + 1 < tbl_cnt; j++) begin
               tbl_lo[j] = tbl_lo[j+1];
               tbl_hi[j] = tbl_hi[j+1];
            end
            tbl_cnt--;
            return;
         end
      end
   endfunction

   function automatic logic coverage_of(logic [63:0] s, logic [63:0] e);
      int unsigned split;
      logic [63:0] reach;
      logic hit;
      split = 0;
      reach = s;
      hit = 1'b0;
      if (s > e) return 1'b0;
      while (split < tbl_cnt && tbl_lo[split] <= s) split++;
      for (int unsigned i = split; i > 0; i--) begin
         if (tbl_hi[i-1] > s) begin
            if (tbl_hi[i-1] > reach) reach = tbl_hi[i-1];
            hit = 1'b1;
            if (reach >= e) return 1'b1;
         end
      end
      if (!hit) return 1'b0;
      // extend forward; a one-address gap still joins
      for (int unsigned i = split; i < tbl_cnt; i++) begin
         if (tbl_lo[i] > reach && tbl_lo[i] - reach > 1) break;
         if (tbl_hi[i] > reach) begin
            reach = tbl_hi[i];
            if (reach >= e) return 1'b1;
         end
      end
      return reach >= e;
   endfunction

   function automatic rsp_word_type predict_word(logic [1:0] k, logic [63:0] s, logic [63:0] b);
      rsp_word_type r;
      r.st = ST_OK;
      r.cov = 1'b0;
      case (k)
         REQ_ADD: begin
            void'(table_add(s, b, r.st));
            if (r.st == ST_OK) n_add++;
            else if (r.st == ST_OVERFLOW) n_ovf++;
            else n_full++;
         end
         REQ_REMOVE: begin
            table_remove(s, b);
            n_rem++;
         end
         REQ_QUERY: begin
            r.cov = coverage_of(s, b);
            if (r.cov) n_hit++;
            else n_miss++;
         end
         default: ;
      endcase
      r.cnt = tbl_cnt[6:0];
      return r;
   endfunction

   // check each response word against the oldest expectation
   always @(posedge clock) begin
      rsp_word_type x;
      if (!reset && rsp_valid) begin
         if (pending_rsp.size() == 0) begin
            $error("response with no pending word");
            err_cnt++;
         end else begin
            x = pending_rsp.pop_front();
            if (rsp_status !== x.st) begin
               $error("rsp_status expected %0d actual %0d", x.st, rsp_status);
               err_cnt++;
            end
            if (rsp_covered !== x.cov) begin
               $error("rsp_covered expected %0d actual %0d", x.cov, rsp_covered);
               err_cnt++;
            end
            if (rsp_entry_count !== x.cnt) begin
               $error("rsp_entry_count expected %0d actual %0d", x.cnt, rsp_entry_count);
               err_cnt++;
            end
         end
      end
   end

   // issue one word, pushing the prediction at acceptance
   task automatic send_word(logic [1:0] k, logic [63:0] s, logic [63:0] b,
                            bit fixed_ok, rsp_word_type fixed);
      rsp_word_type p;
      req_type <= k;
      req_range_start <= s;
      req_range_bound <= b;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      p = predict_word(k, s, b);
      if (fixed_ok && (p.st != fixed.st || p.cov != fixed.cov || p.cnt != fixed.cnt)) begin
         $error("directed row disagrees with model: st %0d cov %0d cnt %0d",
                fixed.st, fixed.cov, fixed.cnt);
         err_cnt++;
      end
      pending_rsp.push_back(fixed_ok ? fixed : p);
   endtask

   // drop start for a random gap, or keep words back to back
   task automatic idle_gap();
      int unsigned n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
      if (n != 0 && $urandom_range(0, 3) != 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // small-window address, clustered so ranges overlap and touch
   function automatic logic [63:0] near_addr(logic [63:0] base);
      return base + 64'($urandom_range(0, 300));
   endfunction

   function automatic dir_row_type mk(logic [1:0] k, logic [63:0] s, logic [63:0] b,
                                      bit f, logic [1:0] st, logic cov, logic [6:0] cnt);
      dir_row_type r;
      r.kind = k; r.lo = s; r.bnd = b; r.has_fixed = f;
      r.fixed.st = st; r.fixed.cov = cov; r.fixed.cnt = cnt;
      return r;
   endfunction

   initial begin
      dir_row_type rows [$];
      logic [63:0] base, s, b;
      int unsigned pick, wait_n;
      tbl_cnt = 0;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      rows.push_back(mk(REQ_QUERY, 0, 0, 1, ST_OK, 0, 0));
      rows.push_back(mk(REQ_REMOVE, 5, 9, 1, ST_OK, 0, 0));
      rows.push_back(mk(REQ_NONE, ADDR_MAX, ADDR_MAX, 1, ST_OK, 0, 0));
      rows.push_back(mk(REQ_ADD, ADDR_MAX, 1, 1, ST_OVERFLOW, 0, 0));
      rows.push_back(mk(REQ_ADD, 1, ADDR_MAX, 1, ST_OVERFLOW, 0, 0));
      rows.push_back(mk(REQ_ADD, 0, ADDR_MAX, 1, ST_OK, 0, 1));
      rows.push_back(mk(REQ_QUERY, 0, ADDR_MAX, 1, ST_OK, 1, 1));
      rows.push_back(mk(REQ_QUERY, 9, 3, 1, ST_OK, 0, 1));
      rows.push_back(mk(REQ_REMOVE, 0, ADDR_MAX, 1, ST_OK, 0, 0));
      rows.push_back(mk(REQ_ADD, 100, 10, 0, 0, 0, 0));
      rows.push_back(mk(REQ_ADD, 111, 10, 0, 0, 0, 0));
      rows.push_back(mk(REQ_QUERY, 100, 121, 0, 0, 0, 0));
      rows.push_back(mk(REQ_ADD, 100, 3, 0, 0, 0, 0));
      rows.push_back(mk(REQ_QUERY, 50, 60, 0, 0, 0, 0));
      rows.push_back(mk(REQ_QUERY, 105, 105, 0, 0, 0, 0));
      rows.push_back(mk(REQ_REMOVE, 100, 103, 0, 0, 0, 0));
      rows.push_back(mk(REQ_ADD, ADDR_MAX - 4, 4, 0, 0, 0, 0));
      rows.push_back(mk(REQ_QUERY, ADDR_MAX - 4, ADDR_MAX, 0, 0, 0, 0));
      rows.push_back(mk(REQ_ADD, ADDR_MAX, 0, 0, 0, 0, 0));
      foreach (rows[i]) begin
         send_word(rows[i].kind, rows[i].lo, rows[i].bnd, rows[i].has_fixed, rows[i].fixed);
         idle_gap();
      end

      // random words: mostly clustered adds/removes/queries, fill to full at times
      base = 64'd1000;
      for (int unsigned n = 0; n < RAND_WORDS; n++) begin
         pick = $urandom_range(0, 99);
         if (n % 300 == 0) base = ($urandom_range(0, 3) == 0) ? ADDR_MAX - 400 : rand64() >> 1;
         if (pick < 45) begin
            s = near_addr(base);
            b = ($urandom_range(0, 19) == 0) ? rand64() : 64'($urandom_range(0, 80));
            send_word(REQ_ADD, s, b, 0, '{default: 0});
         end else if (pick < 62) begin
            if (tbl_cnt > 0 && $urandom_range(0, 3) != 0) begin
               wait_n = $urandom_range(0, tbl_cnt - 1);
               s = tbl_lo[wait_n];
               b = tbl_hi[wait_n];
            end else begin
               s = near_addr(base);
               b = s + 64'($urandom_range(0, 80));
            end
            send_word(REQ_REMOVE, s, b, 0, '{default: 0});
         end else if (pick < 95) begin
            s = near_addr(base);
            b = ($urandom_range(0, 9) == 0) ? rand64() :
                s + 64'($urandom_range(0, 120)) - 64'd10;
            send_word(REQ_QUERY, s, b, 0, '{default: 0});
         end else begin
            send_word(pick[0] ? REQ_NONE : 2'($urandom_range(0, 3)), rand64(), rand64(),
                      0, '{default: 0});
         end
         idle_gap();
      end
      start <= 1'b0;

      // drain
      wait_n = 0;
      while (pending_rsp.size() != 0 && wait_n < 100000) begin
         @(posedge clock);
         wait_n++;
      end
      repeat (2 * TBL_DEPTH + 10) @(posedge clock);
      if (pending_rsp.size() != 0) begin
         $error("%0d responses never arrived", pending_rsp.size());
         err_cnt++;
      end

      $display("Covered %0d adds, %0d overflows, %0d full rejects, %0d removes,",
               n_add, n_ovf, n_full, n_rem);
      $display("and %0d covered / %0d uncovered queries.", n_hit, n_miss);
      if (err_cnt == 0) begin
         $display("sorted_range_table_coverage regression: pass");
      end else begin
         $display("sorted_range_table_coverage regression: fail");
      end
      $finish;
   end
endmodule
